/* rtl/xce_pkg.sv */
// Package for the XML character-data escaper: payload structs, the
// command passed from front to back, and character constants.
// No dependencies.
package xce_pkg;

    // Most bytes one source byte can expand to ("_200_" plus a closing ';')
    localparam int XCE_MAX_OUT = 6;
    localparam int XCE_IDX_W   = 3;

    // Character codes
    localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
    localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
    localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
    localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CH_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CH_UNDER = 8'h5F;  // '_'
    localparam logic [7:0] CH_DASH  = 8'h2D;  // '-'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_UPA   = 8'h41;  // 'A'
    localparam logic [7:0] CH_UPZ   = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_LOA   = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOZ   = 8'h7A;  // 'z'
    localparam logic [7:0] CH_LOM   = 8'h6D;  // 'm'
    localparam logic [7:0] CH_LOP   = 8'h70;  // 'p'
    localparam logic [7:0] CH_LOG   = 8'h67;  // 'g'
    localparam logic [7:0] CH_LOT   = 8'h74;  // 't'

    // Input item
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } xce_in_t;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } xce_out_t;

    // One classified item: the bytes to send and the index of the final one
    typedef struct packed {
        logic [XCE_MAX_OUT-1:0][7:0] bytes;
        logic [XCE_IDX_W-1:0]        last_idx;
    } xce_cmd_t;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic     valid;
        xce_cmd_t cmd;
    } xce_qhead_t;

endpackage

/* rtl/xce_front.sv */
// Front end of the escaper: accepts source bytes, tracks the tag state and
// turns each byte into a command of up to six output bytes.
// Depends on xce_pkg.
module xce_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  xce_pkg::xce_in_t  s_data,
    input  logic              q_full,
    output logic              push,
    output xce_pkg::xce_cmd_t push_cmd
);
    import xce_pkg::*;

    logic inside_tag_reg, inside_tag_next;
    logic at_tag_start_reg, at_tag_start_next;

    logic [7:0]  b;
    logic        is_start;
    logic        is_later;
    logic [1:0]  hund;
    logic [7:0]  rem8;
    logic [6:0]  rem7;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [3:0]  ones;
    logic [2:0]  n_cnt;
    logic [2:0]  last_pos;
    xce_cmd_t    cmd;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;
    assign b       = s_data.in_byte;

    // Name byte classes
    assign is_start = (b == CH_COLON) || (b == CH_UNDER) ||
                      ((b >= CH_UPA) && (b <= CH_UPZ)) ||
                      ((b >= CH_LOA) && (b <= CH_LOZ));
    assign is_later = (b == CH_DASH) || (b == CH_DOT) ||
                      ((b >= CH_ZERO) && (b <= CH_NINE));

    // Decimal digits: hundreds by compare, tens by reciprocal (x205 >> 11)
    assign hund      = (b >= 8'd200) ? 2'd2 : ((b >= 8'd100) ? 2'd1 : 2'd0);
    assign rem8      = b - ((hund == 2'd2) ? 8'd200 : ((hund == 2'd1) ? 8'd100 : 8'd0));
    assign rem7      = rem8[6:0];
    assign tens_prod = 15'(rem7) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign tens_x10  = 7'(tens) * 7'd10;
    assign ones      = 4'(rem7 - tens_x10);

    // Classify the byte and build its command
    always_comb begin
        cmd               = '0;
        n_cnt             = 3'd1;
        inside_tag_next   = inside_tag_reg;
        at_tag_start_next = at_tag_start_reg;
        if (!inside_tag_reg) begin
            priority if (b == CH_AMP) begin
                cmd.bytes[0] = CH_AMP;
                cmd.bytes[1] = CH_LOA;
                cmd.bytes[2] = CH_LOM;
                cmd.bytes[3] = CH_LOP;
                cmd.bytes[4] = CH_SEMI;
                n_cnt        = 3'd5;
            end else if (b == CH_GT) begin
                cmd.bytes[0] = CH_AMP;
                cmd.bytes[1] = CH_LOG;
                cmd.bytes[2] = CH_LOT;
                cmd.bytes[3] = CH_SEMI;
                n_cnt        = 3'd4;
            end else if (b == CH_LT) begin
                cmd.bytes[0]      = CH_AMP;
                inside_tag_next   = 1'b1;
                at_tag_start_next = 1'b1;
            end else begin
                cmd.bytes[0] = b;
            end
        end else begin
            priority if (b == CH_GT) begin
                cmd.bytes[0]      = CH_SEMI;
                inside_tag_next   = 1'b0;
                at_tag_start_next = 1'b0;
            end else if (is_start || (!at_tag_start_reg && is_later)) begin
                cmd.bytes[0]      = b;
                at_tag_start_next = 1'b0;
            end else begin
                // numeric escape without leading zeros
                cmd.bytes[0] = CH_UNDER;
                priority if (hund != 2'd0) begin
                    cmd.bytes[1] = CH_ZERO + 8'(hund);
                    cmd.bytes[2] = CH_ZERO + 8'(tens);
                    cmd.bytes[3] = CH_ZERO + 8'(ones);
                    cmd.bytes[4] = CH_UNDER;
                    n_cnt        = 3'd5;
                end else if (tens != 4'd0) begin
                    cmd.bytes[1] = CH_ZERO + 8'(tens);
                    cmd.bytes[2] = CH_ZERO + 8'(ones);
                    cmd.bytes[3] = CH_UNDER;
                    n_cnt        = 3'd4;
                end else begin
                    cmd.bytes[1] = CH_ZERO + 8'(ones);
                    cmd.bytes[2] = CH_UNDER;
                    n_cnt        = 3'd3;
                end
                at_tag_start_next = 1'b0;
            end
        end
        // end of stream closes any open tag and clears the state
        if (s_data.in_last) begin
            if (inside_tag_next) begin
                cmd.bytes[n_cnt] = CH_SEMI;
                n_cnt            = n_cnt + 3'd1;
            end
            inside_tag_next   = 1'b0;
            at_tag_start_next = 1'b0;
        end
        last_pos     = n_cnt - 3'd1;
        cmd.last_idx = last_pos;
    end

    assign push_cmd = cmd;

    // Tag state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_tag_reg   <= 1'b0;
            at_tag_start_reg <= 1'b0;
        end else if (push) begin
            inside_tag_reg   <= inside_tag_next;
            at_tag_start_reg <= at_tag_start_next;
        end
    end

    // The first tag byte can only be pending inside a tag
    a_start_in_tag: assert property (@(posedge aclk) disable iff (!aresetn)
        at_tag_start_reg |-> inside_tag_reg)
        else $error("at_tag_start set outside a tag");

    // An accepted final byte leaves the block outside any tag
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && s_data.in_last) |=> (!inside_tag_reg && !at_tag_start_reg))
        else $error("tag state survived end of stream");

endmodule

/* rtl/xce_queue.sv */
// Short command queue between front and back end.
// Depends on xce_pkg.
module xce_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  xce_pkg::xce_cmd_t   push_cmd,
    output logic                full,
    input  logic                pop,
    output xce_pkg::xce_qhead_t head
);
    import xce_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xce_cmd_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entries_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

/* rtl/xce_back.sv */
// Back end of the escaper: walks the head command byte by byte into the
// output register and pops it after its final byte.
// Depends on xce_pkg.
module xce_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  xce_pkg::xce_qhead_t head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output xce_pkg::xce_out_t   m_data
);
    import xce_pkg::*;

    logic [XCE_IDX_W-1:0] idx_reg, idx_next;
    logic                 m_valid_reg, m_valid_next;
    xce_out_t             m_data_reg, m_data_next;
    logic                 out_free;
    logic                 at_end;
    logic                 advance;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = out_free && head.valid;
    assign at_end   = (idx_reg == head.cmd.last_idx);
    assign pop      = advance && at_end;

    // Next byte into the output register
    always_comb begin
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            m_valid_next = head.valid;
        end
        if (advance) begin
            m_data_next.out_byte = head.cmd.bytes[idx_reg];
            m_data_next.out_last = at_end;
            idx_next             = at_end ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Mid-expansion the head command must stay in the queue
    a_idx_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != '0) |-> (head.valid && idx_reg <= head.cmd.last_idx))
        else $error("byte index beyond head command");

endmodule

/* rtl/text_to_xml_cdata_escape_top.sv */
// Top level of the XML character-data escaper: front end, command queue
// and back end. Depends on xce_pkg, xce_front, xce_queue, xce_back.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------
//  s_      | in        | s_valid / s_ready  | xce_in_t  {in_byte, in_last}
//  m_      | out       | m_valid / m_ready  | xce_out_t {out_byte, out_last}
//
// One output byte leaves per cycle through the output register while m_ready
// holds; a source byte that expands to n bytes (1 to 6) holds the back end
// until all n have left, so unstalled plain text runs at one item per cycle.
// The front end takes a new item whenever the command queue has room.
// Each accepted byte passes the command queue and then the output register.
// Synchronous active-low reset clears the tag state, queue and output valid.
module text_to_xml_cdata_escape_top #(
    parameter int QUEUE_DEPTH = 2   // command queue entries, 2 to 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  xce_pkg::xce_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output xce_pkg::xce_out_t m_data
);
    import xce_pkg::*;

    logic       q_full;
    logic       push;
    logic       pop;
    xce_cmd_t   push_cmd;
    xce_qhead_t q_head;

    xce_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    xce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head     (q_head)
    );

    xce_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* test/cdata_escape_checker.sv */
// Checker for the XML character-data escaper: watches both channels, predicts
// the escaped bytes of every accepted item and compares them in order.
// Depends on xce_pkg.
`timescale 1ns / 100ps

module cdata_escape_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  xce_pkg::xce_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  xce_pkg::xce_out_t m_data,
    output int                fail_count,
    output int                pending,
    output int                checked
);
    import xce_pkg::*;

    // Predicted tag state
    logic in_tag   = 1'b0;
    logic tag_head = 1'b0;

    xce_out_t escaped_chars[$];
    int       errs      = 0;
    int       n_checked = 0;

    function automatic logic starts_name(input logic [7:0] b);
        return b == CH_COLON || b == CH_UNDER ||
               (b >= CH_UPA && b <= CH_UPZ) || (b >= CH_LOA && b <= CH_LOZ);
    endfunction

    function automatic logic continues_name(input logic [7:0] b);
        return b == CH_DASH || b == CH_DOT || (b >= CH_ZERO && b <= CH_NINE);
    endfunction

    task automatic put_char(input logic [7:0] b);
        xce_out_t r;
        r.out_byte = b;
        r.out_last = 1'b0;
        escaped_chars.push_back(r);
    endtask

    // Escape one source byte into the expected stream; flag its final byte
    task automatic escape_item(input xce_in_t it);
        logic [7:0] b;
        int         h;
        int         t;
        int         o;
        b = it.in_byte;
        if (!in_tag) begin
            if (b == CH_AMP) begin
                put_char(CH_AMP);
                put_char(CH_LOA);
                put_char(CH_LOM);
                put_char(CH_LOP);
                put_char(CH_SEMI);
            end else if (b == CH_GT) begin
                put_char(CH_AMP);
                put_char(CH_LOG);
                put_char(CH_LOT);
                put_char(CH_SEMI);
            end else if (b == CH_LT) begin
                put_char(CH_AMP);
                in_tag   = 1'b1;
                tag_head = 1'b1;
            end else begin
                put_char(b);
            end
        end else if (b == CH_GT) begin
            put_char(CH_SEMI);
            in_tag   = 1'b0;
            tag_head = 1'b0;
        end else begin
            if (starts_name(b) || (!tag_head && continues_name(b))) begin
                put_char(b);
            end else begin
                // numeric escape, no leading zeros
                h = b / 100;
                t = (b / 10) % 10;
                o = b % 10;
                put_char(CH_UNDER);
                if (h != 0) put_char(CH_ZERO + 8'(h));
                if (h != 0 || t != 0) put_char(CH_ZERO + 8'(t));
                put_char(CH_ZERO + 8'(o));
                put_char(CH_UNDER);
            end
            tag_head = 1'b0;
        end
        // end of stream closes any open tag
        if (it.in_last) begin
            if (in_tag) put_char(CH_SEMI);
            in_tag   = 1'b0;
            tag_head = 1'b0;
        end
        escaped_chars[escaped_chars.size() - 1].out_last = 1'b1;
    endtask

    // Predict on accepted input items, compare on accepted results
    always @(posedge aclk) begin
        xce_out_t want;
        if (!aresetn) begin
            in_tag   = 1'b0;
            tag_head = 1'b0;
            escaped_chars.delete();
        end else begin
            if (s_valid && s_ready) escape_item(s_data);
            if (m_valid && m_ready) begin
                if (escaped_chars.size() == 0) begin
                    errs++;
                    $display("%0t: unexpected item, expected none, got byte %h last %b",
                             $time, m_data.out_byte, m_data.out_last);
                end else begin
                    want = escaped_chars.pop_front();
                    n_checked++;
                    if (m_data.out_byte !== want.out_byte) begin
                        errs++;
                        $display("%0t: out_byte mismatch, expected %h, got %h",
                                 $time, want.out_byte, m_data.out_byte);
                    end
                    if (m_data.out_last !== want.out_last) begin
                        errs++;
                        $display("%0t: out_last mismatch, expected %b, got %b",
                                 $time, want.out_last, m_data.out_last);
                    end
                end
            end
        end
        fail_count <= errs;
        pending    <= escaped_chars.size();
        checked    <= n_checked;
    end

endmodule

/* test/text_to_xml_cdata_escape_top_test.sv */
// Testbench top for the XML character-data escaper: clock, reset, stimulus,
// output stalls and the verdict. Depends on xce_pkg, cdata_escape_checker
// and text_to_xml_cdata_escape_top.
`timescale 1ns / 100ps

module text_to_xml_cdata_escape_top_test;
    import xce_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 145;
    localparam int QUIET_TAIL   = 30;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     m_ready = 1'b0;
    xce_in_t  s_data  = '0;
    logic     s_ready;
    logic     m_valid;
    xce_out_t m_data;

    int   fail_count;
    int   pending;
    int   checked;
    logic idle_on    = 1'b0;
    int   stall_left = 0;
    int   cycles     = 0;
    int   n_items    = 0;
    int   n_tags     = 0;
    int   n_streams  = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    text_to_xml_cdata_escape_top uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    cdata_escape_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // Random result-side stalls while idle_on is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("text_to_xml_cdata_escape_top_test: done, errors");
            $finish;
        end
    end

    // Offer one item, with an occasional gap before it, and wait for acceptance
    task automatic send_byte(input logic [7:0] b, input logic fin);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{in_byte: b, in_last: fin};
        do @(posedge aclk); while (!s_ready);
        n_items++;
        if (fin) n_streams++;
    endtask

    // Byte for inside a tag: mostly name characters, some anything
    function automatic logic [7:0] name_char();
        case ($urandom_range(0, 6))
            0:       return CH_UPA + 8'($urandom_range(0, 25));
            1:       return CH_LOA + 8'($urandom_range(0, 25));
            2:       return CH_ZERO + 8'($urandom_range(0, 9));
            3:       return CH_DASH;
            4:       return CH_DOT;
            5:       return $urandom_range(0, 1) ? CH_COLON : CH_UNDER;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Byte for plain text: printable, the escaped ones, or anything
    function automatic logic [7:0] text_char();
        case ($urandom_range(0, 6))
            0, 1, 2, 3: return 8'($urandom_range(32, 126));
            4:          return CH_AMP;
            5:          return CH_GT;
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        int base;
        int pick;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        idle_on  = 1'b1;

        // Directed: pass-through extremes, the escapes, empty tag
        send_byte(CH_UPA, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_AMP, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_GT, 1'b0);
        // name characters, then numeric escapes of one, two and three digits
        send_byte(CH_LT, 1'b0);
        send_byte(CH_COLON, 1'b0);
        send_byte(CH_LOZ, 1'b0);
        send_byte(CH_NINE, 1'b0);
        send_byte(CH_DASH, 1'b0);
        send_byte(CH_DOT, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h20, 1'b0);
        send_byte(8'hC8, 1'b0);
        send_byte(8'hFF, 1'b0);
        // closing bracket as the final byte
        send_byte(CH_GT, 1'b1);
        // digit and dot not allowed to open a name
        send_byte(CH_LT, 1'b0);
        send_byte(CH_ZERO, 1'b0);
        send_byte(CH_GT, 1'b0);
        send_byte(CH_LT, 1'b0);
        send_byte(CH_DOT, 1'b0);
        // tag left open at end of stream, and a lone final '<'
        send_byte(CH_UNDER, 1'b1);
        send_byte(CH_LT, 1'b1);
        send_byte(CH_LOA, 1'b1);
        n_tags += 5;

        // Random: mostly text runs and tags with random content
        base = n_items;
        while (n_items - base < RANDOM_ITEMS) begin
            idle_on = (n_items - base < RANDOM_ITEMS - QUIET_TAIL) &&
                      (((n_items - base) / 40) % 3 != 2);
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 6)) send_byte(text_char(), 1'b0);
                end
                4, 5, 6, 7: begin
                    send_byte(CH_LT, 1'b0);
                    n_tags++;
                    repeat ($urandom_range(0, 5)) send_byte(name_char(), 1'b0);
                    case ($urandom_range(0, 5))
                        0:       send_byte(name_char(), 1'b1);
                        1:       send_byte(CH_GT, 1'b1);
                        default: send_byte(CH_GT, 1'b0);
                    endcase
                end
                8: begin
                    send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
                end
                default: begin
                    send_byte(text_char(), 1'b1);
                end
            endcase
        end

        // Drain
        s_valid <= 1'b0;
        idle_on  = 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (12) @(posedge aclk);

        $display("Run covered %0d source bytes in %0d streams, %0d tags opened,",
                 n_items, n_streams, n_tags);
        $display("and compared %0d escaped output bytes.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("text_to_xml_cdata_escape_top_test: done, clean");
        end else begin
            $display("text_to_xml_cdata_escape_top_test: done, errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/xce_pkg.sv
rtl/xce_front.sv
rtl/xce_queue.sv
rtl/xce_back.sv
rtl/text_to_xml_cdata_escape_top.sv
test/cdata_escape_checker.sv
test/text_to_xml_cdata_escape_top_test.sv
